FILE: rtl/nspw_pkg.sv
// ----------------------------------------------------------------------------
// nspw_pkg
// Shared types and constants for the pumped noise source and debiaser.
// ----------------------------------------------------------------------------
package nspw_pkg;

  localparam int ADC_BITS_DEF = 10;
  localparam int OUT_BITS_DEF = 8;

  localparam int LIMIT_W  = 10;
  localparam int TICK_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_HIGH_RST  = 10'd800;
  localparam logic [LIMIT_W-1:0] LIMIT_LOW_RST   = 10'd600;
  localparam logic [TICK_W-1:0]  ALARM_TICKS_RST = 16'd1000;
  localparam logic [TICK_W-1:0]  TICK_MAX        = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIMIT_HIGH  = 2'd0,
    REG_LIMIT_LOW   = 2'd1,
    REG_ALARM_TICKS = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_SENSE = 2'd0,
    CMD_NOISE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    MODE_CHECK   = 4'b0001,
    MODE_CHARGE  = 4'b0010,
    MODE_VERIFY  = 4'b0100,
    MODE_COLLECT = 4'b1000
  } mode_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] limit_high;
    logic [LIMIT_W-1:0] limit_low;
    logic [TICK_W-1:0]  alarm_ticks;
  } cfg_t;

  typedef struct packed {
    logic drive_en;
    logic phase;
    logic byte_valid;
    logic good;
  } res_flags_t;

endpackage

FILE: rtl/nspw_cfg.sv
// ----------------------------------------------------------------------------
// nspw_cfg
// Configuration register file: limits and charge alarm.
// ----------------------------------------------------------------------------
module nspw_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [nspw_pkg::CFG_IDX_W-1:0]  wr_idx_i,
  input  logic [nspw_pkg::CFG_DATA_W-1:0] wr_data_i,
  output nspw_pkg::cfg_t                 cfg_o
);
  import nspw_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        REG_LIMIT_HIGH:  cfg_d.limit_high  = wr_data_i[LIMIT_W-1:0];
        REG_LIMIT_LOW:   cfg_d.limit_low   = wr_data_i[LIMIT_W-1:0];
        REG_ALARM_TICKS: cfg_d.alarm_ticks = wr_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit_high  <= LIMIT_HIGH_RST;
      cfg_q.limit_low   <= LIMIT_LOW_RST;
      cfg_q.alarm_ticks <= ALARM_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/nspw_core.sv
// ----------------------------------------------------------------------------
// nspw_core
// Mode sequencer: check, charge, verify, collect; pair debiaser and shifter.
// ----------------------------------------------------------------------------
module nspw_core #(
  parameter int ADC_BITS = nspw_pkg::ADC_BITS_DEF,
  parameter int OUT_BITS = nspw_pkg::OUT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [1:0]           cmd_i,
  input  logic [ADC_BITS-1:0]  adc_value_i,
  input  nspw_pkg::cfg_t       cfg_i,
  output nspw_pkg::res_flags_t flags_o,
  output logic [OUT_BITS-1:0]  byte_o
);
  import nspw_pkg::*;

  localparam int CmpW = (ADC_BITS > LIMIT_W) ? ADC_BITS : LIMIT_W;
  localparam int CntW = $clog2(OUT_BITS + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(OUT_BITS - 1);

  mode_e               mode_q, mode_d;
  logic                phase_q, phase_d;
  logic                drive_q, drive_d;
  logic [TICK_W-1:0]   ticks_q, ticks_d;
  logic                first_q, first_d;
  logic                half_q, half_d;
  logic [OUT_BITS-1:0] shift_q, shift_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                good_q, good_d;

  logic [CmpW-1:0]     adc_ext, hi_ext, lo_ext;
  logic                above_low, below_high;
  logic [OUT_BITS:0]   shift_ext;
  logic [TICK_W-1:0]   ticks_inc;
  logic                bit_in;
  logic                emit;
  logic [OUT_BITS-1:0] byte_d;

  assign adc_ext    = CmpW'(adc_value_i);
  assign hi_ext     = CmpW'(cfg_i.limit_high);
  assign lo_ext     = CmpW'(cfg_i.limit_low);
  assign above_low  = adc_ext > lo_ext;
  assign below_high = adc_ext < hi_ext;
  assign bit_in     = adc_value_i[0];
  assign shift_ext  = {shift_q, bit_in};
  assign ticks_inc  = (ticks_q == TICK_MAX) ? ticks_q : ticks_q + 1'b1;

  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    drive_d = drive_q;
    ticks_d = ticks_q;
    first_d = first_q;
    half_d  = half_q;
    shift_d = shift_q;
    cnt_d   = cnt_q;
    good_d  = good_q;
    emit    = 1'b0;
    byte_d  = '0;

    case (cmd_i)
      CMD_SENSE: begin
        case (mode_q)
          MODE_CHECK, MODE_VERIFY: begin
            if (above_low) begin
              good_d  = 1'b1;
              half_d  = 1'b0;
              first_d = 1'b0;
              shift_d = '0;
              cnt_d   = '0;
              mode_d  = MODE_COLLECT;
            end else if (mode_q == MODE_CHECK) begin
              phase_d = 1'b0;
              ticks_d = '0;
              drive_d = 1'b1;
              mode_d  = MODE_CHARGE;
            end else begin
              // verify failed: report a zero item, source bad
              good_d = 1'b0;
              emit   = 1'b1;
              mode_d = MODE_CHECK;
            end
          end
          MODE_CHARGE: begin
            if (below_high) begin
              phase_d = ~phase_q;
            end else begin
              drive_d = 1'b0;
              mode_d  = MODE_VERIFY;
            end
          end
          default: ;
        endcase
      end
      CMD_NOISE: begin
        if (mode_q == MODE_COLLECT && adc_value_i != '0) begin
          if (!half_q) begin
            first_d = bit_in;
            half_d  = 1'b1;
          end else begin
            half_d = 1'b0;
            if (bit_in != first_q) begin
              if (cnt_q >= LastCnt) begin
                emit    = 1'b1;
                byte_d  = shift_ext[OUT_BITS-1:0];
                shift_d = '0;
                cnt_d   = '0;
                mode_d  = MODE_CHECK;
              end else begin
                shift_d = shift_ext[OUT_BITS-1:0];
                cnt_d   = cnt_q + 1'b1;
              end
            end
          end
        end
      end
      CMD_TICK: begin
        if (mode_q == MODE_CHARGE) begin
          ticks_d = ticks_inc;
          // timeout also releases the pump
          if (ticks_inc > cfg_i.alarm_ticks) begin
            drive_d = 1'b0;
            mode_d  = MODE_VERIFY;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_CHECK;
      phase_q <= 1'b0;
      drive_q <= 1'b0;
      ticks_q <= '0;
      first_q <= 1'b0;
      half_q  <= 1'b0;
      shift_q <= '0;
      cnt_q   <= '0;
      good_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      drive_q <= drive_d;
      ticks_q <= ticks_d;
      first_q <= first_d;
      half_q  <= half_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
      good_q  <= good_d;
    end
  end

  assign flags_o.drive_en   = drive_d;
  assign flags_o.phase      = phase_d;
  assign flags_o.byte_valid = emit;
  assign flags_o.good       = good_d;
  assign byte_o             = byte_d;

`ifndef ASSERT_OFF
  // pump is driven exactly while charging
  a_drive_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_q == (mode_q == MODE_CHARGE))
    else $error("pump drive out of step with charge mode");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CntW'(OUT_BITS))
    else $error("bit count past output width");

  a_emit_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && emit |=> mode_q == MODE_CHECK)
    else $error("emitted item did not return to check");
`endif

endmodule

FILE: rtl/nspw_skid.sv
// ----------------------------------------------------------------------------
// nspw_skid
// Two-entry result buffer: output register plus skid slot.
// ----------------------------------------------------------------------------
module nspw_skid #(
  parameter int DW = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          up_valid_i,
  output logic          up_stall_o,
  input  logic [DW-1:0] up_data_i,
  output logic          dn_valid_o,
  input  logic          dn_stall_i,
  output logic [DW-1:0] dn_data_o
);

  logic          main_valid_q, skid_valid_q;
  logic [DW-1:0] main_q, skid_q;
  logic          up_take, dn_take;

  assign up_stall_o = skid_valid_q;
  assign up_take    = up_valid_i && !skid_valid_q;
  assign dn_take    = main_valid_q && !dn_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (dn_take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (main_valid_q && !dn_take) begin
        skid_valid_q <= up_take;
      end else begin
        main_valid_q <= up_take;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (dn_take) begin
        main_q <= skid_q;
      end
    end else if (main_valid_q && !dn_take) begin
      if (up_take) begin
        skid_q <= up_data_i;
      end
    end else if (up_take) begin
      main_q <= up_data_i;
    end
  end

  assign dn_valid_o = main_valid_q;
  assign dn_data_o  = main_q;

`ifndef ASSERT_OFF
  a_skid_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid slot full with output register empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(main_valid_q && dn_stall_i))
    else $error("skid slot filled without a stalled output");

  a_skid_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !dn_stall_i |=> main_valid_q && !skid_valid_q)
    else $error("skid item lost on drain");
`endif

endmodule

FILE: rtl/noise_source_pump_whitener_top.sv
// ----------------------------------------------------------------------------
// noise_source_pump_whitener_top
// Charge-pumped noise source controller with pair debiaser.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one item per cycle unless
//   stalled: a sense sample, a noise sample or a millisecond tick. Every
//   accepted item yields exactly one result on the output channel
//   (out_valid_o / out_stall_i): pump drive and phase, source status, and a
//   random byte when one is done. The mode sequencer and debiaser are a
//   single pass of compare/shift logic into the output register, which
//   limits throughput only while the receiver stalls.
//   If the receiver stalls, one more result is held in a skid slot; after
//   that in_stall_o rises until the output drains.
//   Config writes (cfg_valid_i / cfg_ready_o) are always taken; write them
//   only while no items are in flight.
//   Reset puts the block in check mode with the pump released, source status
//   low, limits at 800 / 600 and the alarm at 1000 ticks.
// ----------------------------------------------------------------------------
module noise_source_pump_whitener_top #(
  parameter int ADC_BITS = nspw_pkg::ADC_BITS_DEF,
  parameter int OUT_BITS = nspw_pkg::OUT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      cmd_i,
  input  logic [ADC_BITS-1:0]             adc_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            pump_drive_enable_o,
  output logic                            pump_phase_o,
  output logic [OUT_BITS-1:0]             random_byte_o,
  output logic                            byte_valid_o,
  output logic                            source_good_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nspw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nspw_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import nspw_pkg::*;

  localparam int FlagW = $bits(res_flags_t);
  localparam int ResW  = OUT_BITS + FlagW;

  cfg_t                cfg;
  res_flags_t          flags, flags_out;
  logic [OUT_BITS-1:0] res_byte;
  logic [ResW-1:0]     res_in, res_out;
  logic                accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;

  nspw_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  nspw_core #(
    .ADC_BITS (ADC_BITS),
    .OUT_BITS (OUT_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cmd_i       (cmd_i),
    .adc_value_i (adc_value_i),
    .cfg_i       (cfg),
    .flags_o     (flags),
    .byte_o      (res_byte)
  );

  assign res_in = {res_byte, flags};

  nspw_skid #(
    .DW (ResW)
  ) u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (in_valid_i),
    .up_stall_o (in_stall_o),
    .up_data_i  (res_in),
    .dn_valid_o (out_valid_o),
    .dn_stall_i (out_stall_i),
    .dn_data_o  (res_out)
  );

  assign flags_out           = res_flags_t'(res_out[FlagW-1:0]);
  assign random_byte_o       = res_out[ResW-1:FlagW];
  assign pump_drive_enable_o = flags_out.drive_en;
  assign pump_phase_o        = flags_out.phase;
  assign byte_valid_o        = flags_out.byte_valid;
  assign source_good_o       = flags_out.good;

endmodule
